// ----- src/sampson_inlier_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Sampson inlier filter
// Both macros expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SAMPSON_INLIER_FILTER_MACROS_SVH
`define SAMPSON_INLIER_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SIF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sif_pkg.sv -----
// ----------------------------------------------------------------------------
// sif_pkg
// Widths, types and register codes of the Sampson inlier filter.
// ----------------------------------------------------------------------------
package sif_pkg;

	localparam int COORD_WIDTH     = 20;
	localparam int COEF_WIDTH      = 32;
	localparam int COORD_FRAC      = 4;   // homogeneous 1.0 is 1 << COORD_FRAC
	localparam int REG_WIDTH       = 64;
	localparam int HALF_WIDTH      = 32;
	localparam int DIST_WIDTH      = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [DIST_WIDTH-1:0] MAX_DIST_RESET = DIST_WIDTH'(256);

	// F * coordinate products and the F*x vectors
	localparam int PW  = COEF_WIDTH + COORD_WIDTH;
	localparam int BW  = PW + 2;
	localparam int BL  = BW / 2;
	localparam int BHW = BW - BL;
	localparam int SQW = 2 * BW;
	localparam int DW  = SQW + 2;

	// epipolar numerator and its square
	localparam int NW  = BW + COORD_WIDTH + 2;
	localparam int NL  = (NW + 2) / 3;
	localparam int NTW = NW - 2 * NL;
	localparam int QW  = 2 * NW;

	// band thresholds
	localparam int D_LIMBS = 4;
	localparam int DL      = (DW + D_LIMBS - 1) / D_LIMBS;
	localparam int TW      = DIST_WIDTH + DW;
	localparam int CMPW    = (QW > TW) ? QW : TW;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic [DIST_WIDTH-1:0]         dist_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
	} pair_t;

	typedef logic signed [PW-1:0]             prod_t;
	typedef logic signed [BW-1:0]             bvec_t;
	typedef logic signed [BHW-1:0]            bhi_t;
	typedef logic signed [BL:0]               blo_t;
	typedef logic signed [2*BHW-1:0]          bhh_t;
	typedef logic signed [BHW+BL:0]           bhl_t;
	typedef logic signed [2*BL+1:0]           bll_t;
	typedef logic signed [SQW-1:0]            sq_t;
	typedef logic signed [BHW+COORD_WIDTH-1:0] nph_t;
	typedef logic signed [BL+COORD_WIDTH:0]   npl_t;
	typedef logic signed [NW-1:0]             nvec_t;
	typedef logic signed [NTW-1:0]            ntop_t;
	typedef logic signed [NL:0]               nlo_t;
	typedef logic signed [2*NTW-1:0]          ntt_t;
	typedef logic signed [NTW+NL:0]           ntl_t;
	typedef logic signed [2*NL+1:0]           nll_t;
	typedef logic signed [QW-1:0]             qw_t;
	typedef logic [QW-1:0]                    nsq_t;
	typedef logic [DW-1:0]                    dvec_t;
	typedef logic [DL-1:0]                    dlimb_t;
	typedef logic [DIST_WIDTH+DL-1:0]         tprod_t;
	typedef logic [TW-1:0]                    tvec_t;
	typedef logic [CMPW-1:0]                  cmp_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_F_PAIR_A,
		REG_F_PAIR_B,
		REG_F_PAIR_C,
		REG_F_PAIR_D,
		REG_F_CORNER,
		REG_MAX_DIST_SQ,
		REG_MIN_DIST_SQ
	} cfg_reg_t;

endpackage

// ----- src/sif_pair_in_if.sv -----
// ----------------------------------------------------------------------------
// sif_pair_in_if
// Point correspondence channel into the filter.
// ----------------------------------------------------------------------------
interface sif_pair_in_if;
	import sif_pkg::*;

	logic   valid;
	logic   ready;
	coord_t first_x;
	coord_t first_y;
	coord_t second_x;
	coord_t second_y;

	modport source (output valid, output first_x, output first_y,
		output second_x, output second_y, input ready);
	modport sink (input valid, input first_x, input first_y,
		input second_x, input second_y, output ready);
endinterface

// ----- src/sif_pair_out_if.sv -----
// ----------------------------------------------------------------------------
// sif_pair_out_if
// Channel of correspondences kept by the filter.
// ----------------------------------------------------------------------------
interface sif_pair_out_if;
	import sif_pkg::*;

	logic   valid;
	logic   ready;
	coord_t kept_first_x;
	coord_t kept_first_y;
	coord_t kept_second_x;
	coord_t kept_second_y;

	modport source (output valid, output kept_first_x, output kept_first_y,
		output kept_second_x, output kept_second_y, input ready);
	modport sink (input valid, input kept_first_x, input kept_first_y,
		input kept_second_x, input kept_second_y, output ready);
endinterface

// ----- src/sampson_inlier_filter.sv -----
// ----------------------------------------------------------------------------
// sampson_inlier_filter
// Epipolar band test on the Sampson distance of point correspondences.
// ----------------------------------------------------------------------------
// The filter takes one correspondence per cycle while its output is not
// stalled and passes it on unchanged when min^2 * d < n^2 < max^2 * d and
// d > 0, with n = x2'F x1 and d the sum of squares of the first two entries
// of F x1 and F'x2; all arithmetic is exact. A kept pair is offered at the
// output after the eight register stages of the multiply chain (F*x
// products, sums, split squares, squares and n, d and split n^2, n^2 and
// threshold limbs, threshold sums, compare); dropped pairs leave no
// output. The whole pipeline advances whenever the output register is empty
// or being taken, so a stalled output freezes every stage and loses nothing.
// Write F and the bounds only while no pair is in flight.

`include "sampson_inlier_filter_macros.svh"

module sampson_inlier_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sif_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [sif_pkg::REG_WIDTH-1:0]       cfg_data,
	sif_pair_in_if.sink                         pair_in,
	sif_pair_out_if.source                      pair_out
);
	import sif_pkg::*;

	// configuration
	coef_t f_q [3][3];
	dist_t max_q;
	dist_t min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					f_q[r][c] <= '0;
				end
			end
			max_q <= MAX_DIST_RESET;
			min_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_F_PAIR_A: begin
					f_q[0][0] <= cfg_data[HALF_WIDTH +: COEF_WIDTH];
					f_q[0][1] <= cfg_data[0 +: COEF_WIDTH];
				end
				REG_F_PAIR_B: begin
					f_q[0][2] <= cfg_data[HALF_WIDTH +: COEF_WIDTH];
					f_q[1][0] <= cfg_data[0 +: COEF_WIDTH];
				end
				REG_F_PAIR_C: begin
					f_q[1][1] <= cfg_data[HALF_WIDTH +: COEF_WIDTH];
					f_q[1][2] <= cfg_data[0 +: COEF_WIDTH];
				end
				REG_F_PAIR_D: begin
					f_q[2][0] <= cfg_data[HALF_WIDTH +: COEF_WIDTH];
					f_q[2][1] <= cfg_data[0 +: COEF_WIDTH];
				end
				REG_F_CORNER:    f_q[2][2] <= cfg_data[0 +: COEF_WIDTH];
				REG_MAX_DIST_SQ: max_q <= cfg_data[0 +: DIST_WIDTH];
				REG_MIN_DIST_SQ: min_q <= cfg_data[0 +: DIST_WIDTH];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic pass;
	pair_t pair_in_w;
	pair_t pair_s1, pair_s2, pair_s3, pair_s4, pair_s5, pair_s6, pair_s7, pair_s8;

	assign adv           = !v_s8 || pair_out.ready;
	assign pair_in.ready = adv;

	assign pair_in_w.first_x  = pair_in.first_x;
	assign pair_in_w.first_y  = pair_in.first_y;
	assign pair_in_w.second_x = pair_in.second_x;
	assign pair_in_w.second_y = pair_in.second_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			// drop pairs outside the band here
			v_s8 <= v_s7 && pass;
		end
	end

	// stage 1: F entries times coordinates
	prod_t pr1_s1 [3][2];
	prod_t pc2_s1 [2][2];

	// stage 2: F x1 rows and F'x2 columns
	bvec_t b1_w [3];
	bvec_t b2_w [2];
	bvec_t b1_s2 [3];
	bvec_t b2_s2 [2];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			b1_w[r] = bvec_t'(pr1_s1[r][0]) + bvec_t'(pr1_s1[r][1])
				+ (bvec_t'(f_q[r][2]) <<< COORD_FRAC);
		end
		for (int c = 0; c < 2; c++) begin
			b2_w[c] = bvec_t'(pc2_s1[c][0]) + bvec_t'(pc2_s1[c][1])
				+ (bvec_t'(f_q[2][c]) <<< COORD_FRAC);
		end
	end

	// stage 3: split partial products of the squares and of n
	bvec_t bsel_w [4];
	bhi_t  bh_w [4];
	blo_t  bl_w [4];
	bhh_t  hh_s3 [4];
	bhl_t  hl_s3 [4];
	bll_t  ll_s3 [4];
	nph_t  nph_s3 [2];
	npl_t  npl_s3 [2];
	bvec_t b13_s3;

	always_comb begin
		bsel_w[0] = b1_s2[0];
		bsel_w[1] = b1_s2[1];
		bsel_w[2] = b2_s2[0];
		bsel_w[3] = b2_s2[1];
		for (int k = 0; k < 4; k++) begin
			bh_w[k] = bsel_w[k][BW-1:BL];
			bl_w[k] = {1'b0, bsel_w[k][BL-1:0]};
		end
	end

	// stage 4: reassemble the squares and n
	sq_t   sqr_w [4];
	sq_t   sqr_s4 [4];
	nvec_t n_w;
	nvec_t n_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sqr_w[k] = (sq_t'(hh_s3[k]) <<< (2 * BL)) + (sq_t'(hl_s3[k]) <<< (BL + 1))
				+ sq_t'(ll_s3[k]);
		end
		n_w = (nvec_t'(nph_s3[0]) <<< BL) + nvec_t'(npl_s3[0])
			+ (nvec_t'(nph_s3[1]) <<< BL) + nvec_t'(npl_s3[1])
			+ (nvec_t'(b13_s3) <<< COORD_FRAC);
	end

	// stage 5: d, and split partial products of n^2
	dvec_t d_s5;
	ntop_t nt_w;
	nlo_t  n1_w;
	nlo_t  n0_w;
	ntt_t  t22_s5;
	ntl_t  t21_s5, t20_s5;
	nll_t  t11_s5, t10_s5, t00_s5;

	assign nt_w = n_s4[NW-1:2*NL];
	assign n1_w = {1'b0, n_s4[2*NL-1:NL]};
	assign n0_w = {1'b0, n_s4[NL-1:0]};

	// stage 6: n^2, and limb products of the thresholds
	qw_t    n2_w;
	nsq_t   n2_s6;
	dlimb_t dl_w [D_LIMBS];
	tprod_t hp_s6 [D_LIMBS];
	tprod_t lp_s6 [D_LIMBS];
	logic   dnz_s6;

	always_comb begin
		n2_w = (qw_t'(t22_s5) <<< (4 * NL)) + (qw_t'(t21_s5) <<< (3 * NL + 1))
			+ (qw_t'(t20_s5) <<< (2 * NL + 1)) + (qw_t'(t11_s5) <<< (2 * NL))
			+ (qw_t'(t10_s5) <<< (NL + 1)) + qw_t'(t00_s5);
		for (int k = 0; k < D_LIMBS - 1; k++) begin
			dl_w[k] = d_s5[k*DL +: DL];
		end
		dl_w[D_LIMBS-1] = DL'(d_s5[DW-1:(D_LIMBS-1)*DL]);
	end

	// stage 7: threshold sums
	tvec_t hi_w, lo_w;
	tvec_t hi_s7, lo_s7;
	nsq_t  n2_s7;
	logic  dnz_s7;

	always_comb begin
		hi_w = '0;
		lo_w = '0;
		for (int k = 0; k < D_LIMBS; k++) begin
			hi_w = hi_w + (tvec_t'(hp_s6[k]) << (k * DL));
			lo_w = lo_w + (tvec_t'(lp_s6[k]) << (k * DL));
		end
	end

	// stage 8: open band compare
	cmp_t n2_c, hi_c, lo_c;

	assign n2_c = cmp_t'(n2_s7);
	assign hi_c = cmp_t'(hi_s7);
	assign lo_c = cmp_t'(lo_s7);
	assign pass = dnz_s7 && (lo_c < n2_c) && (n2_c < hi_c);

	// payload registers: advance together, hold on stall
	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s1 <= pair_in_w;
			for (int r = 0; r < 3; r++) begin
				pr1_s1[r][0] <= f_q[r][0] * pair_in_w.first_x;
				pr1_s1[r][1] <= f_q[r][1] * pair_in_w.first_y;
			end
			for (int c = 0; c < 2; c++) begin
				pc2_s1[c][0] <= f_q[0][c] * pair_in_w.second_x;
				pc2_s1[c][1] <= f_q[1][c] * pair_in_w.second_y;
			end

			pair_s2 <= pair_s1;
			b1_s2   <= b1_w;
			b2_s2   <= b2_w;

			pair_s3 <= pair_s2;
			for (int k = 0; k < 4; k++) begin
				hh_s3[k] <= bh_w[k] * bh_w[k];
				hl_s3[k] <= bh_w[k] * bl_w[k];
				ll_s3[k] <= bl_w[k] * bl_w[k];
			end
			nph_s3[0] <= bh_w[0] * pair_s2.second_x;
			npl_s3[0] <= bl_w[0] * pair_s2.second_x;
			nph_s3[1] <= bh_w[1] * pair_s2.second_y;
			npl_s3[1] <= bl_w[1] * pair_s2.second_y;
			b13_s3    <= b1_s2[2];

			pair_s4 <= pair_s3;
			sqr_s4  <= sqr_w;
			n_s4    <= n_w;

			pair_s5 <= pair_s4;
			d_s5    <= dvec_t'(sqr_s4[0]) + dvec_t'(sqr_s4[1])
				+ dvec_t'(sqr_s4[2]) + dvec_t'(sqr_s4[3]);
			t22_s5  <= nt_w * nt_w;
			t21_s5  <= nt_w * n1_w;
			t20_s5  <= nt_w * n0_w;
			t11_s5  <= n1_w * n1_w;
			t10_s5  <= n1_w * n0_w;
			t00_s5  <= n0_w * n0_w;

			pair_s6 <= pair_s5;
			n2_s6   <= nsq_t'(n2_w);
			for (int k = 0; k < D_LIMBS; k++) begin
				hp_s6[k] <= max_q * dl_w[k];
				lp_s6[k] <= min_q * dl_w[k];
			end
			dnz_s6  <= |d_s5;

			pair_s7 <= pair_s6;
			n2_s7   <= n2_s6;
			hi_s7   <= hi_w;
			lo_s7   <= lo_w;
			dnz_s7  <= dnz_s6;

			pair_s8 <= pair_s7;
		end
	end

	assign pair_out.valid         = v_s8;
	assign pair_out.kept_first_x  = pair_s8.first_x;
	assign pair_out.kept_first_y  = pair_s8.first_y;
	assign pair_out.kept_second_x = pair_s8.second_x;
	assign pair_out.kept_second_y = pair_s8.second_y;

	`SIF_ASSERT_NEXT(a_valid_travels, adv && v_s3, v_s4, "pair lost between stages 3 and 4")
	`SIF_ASSERT_NEXT(a_stall_holds, !adv && v_s6, v_s6 && $stable(n2_s6),
		"stage 6 changed during a stall")
	`SIF_ASSERT_NEXT(a_zero_denominator_drops, adv && v_s7 && !dnz_s7, !v_s8,
		"pair with zero denominator was kept")

endmodule
